FILE: rtl/lruc_pkg.sv
// lruc_pkg: shared constants, codes and cell control types for the lru object cache tags
// used by the interfaces, the slot cell and the top level
`default_nettype none

package lruc_pkg;

	localparam int NUM_SLOTS      = 32;
	localparam int SLOT_BITS      = $clog2(NUM_SLOTS);
	localparam int KEY_BITS       = 32;
	localparam int SIZE_BITS      = 14;
	localparam int OBJ_SIZE_BITS  = 16;
	localparam int CNT_BITS       = 32;
	localparam int MAX_SIZE_LIMIT = 8192;
	localparam int CFG_RESET      = 8192;

	typedef enum logic [2:0] {
		OP_ADD     = 3'd0,
		OP_REWRITE = 3'd1,
		OP_DELETE  = 3'd2,
		OP_SIZE    = 3'd3,
		OP_GET     = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_MRU,
		ACT_LRU,
		ACT_FILL
	} act_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		act_t                 act;
		logic [SLOT_BITS-1:0] target_rank;
		logic [KEY_BITS-1:0]  key;
		logic [SIZE_BITS-1:0] size;
	} cell_cmd_t;

	// what each cell reports back
	typedef struct packed {
		logic                 match;
		logic                 sel;
		logic [SLOT_BITS-1:0] rank;
		logic [SIZE_BITS-1:0] size;
	} cell_stat_t;

endpackage

`default_nettype wire

FILE: rtl/lruc_if.sv
// lruc_in_if / lruc_out_if: valid-ready channels for request and result words
// depends on lruc_pkg for field widths
`default_nettype none

interface lruc_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [2:0]                           operation;
	logic [lruc_pkg::KEY_BITS-1:0]        object_key;
	logic [lruc_pkg::OBJ_SIZE_BITS-1:0]   obj_bytes;
	logic                                 store_ok;

	modport source (output valid, operation, object_key, obj_bytes, store_ok,
		input ready);
	modport sink (input valid, operation, object_key, obj_bytes, store_ok,
		output ready);
endinterface

interface lruc_out_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 status;
	logic                                 hit;
	logic [lruc_pkg::SLOT_BITS-1:0]       slot_index;
	logic                                 slot_written;
	logic [lruc_pkg::SIZE_BITS-1:0]       cached_size;
	logic [lruc_pkg::CNT_BITS-1:0]        hit_count;
	logic [lruc_pkg::CNT_BITS-1:0]        miss_count;

	modport source (output valid, status, hit, slot_index, slot_written, cached_size,
		hit_count, miss_count, input ready);
	modport sink (input valid, status, hit, slot_index, slot_written, cached_size,
		hit_count, miss_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/lru_object_cache_tags_core.sv
// lru_object_cache_tags_core: top level, request control, counters and config register
// depends on lruc_pkg, lruc_if and lruc_cell
//
// usage:
//   in_ch carries one request word (operation, object_key, obj_bytes, store_ok);
//   out_ch returns exactly one result word per request, in order.
//   in the accept cycle every slot cell compares its key against the request and the
//   least recently used match is captured; in ST_UPD, once out_ch can take a word, the
//   controller broadcasts one update to the row of cells and loads the result register.
//   a new request is taken only in ST_IDLE, so the compare and the rank update over the
//   cell row for one request are both done before the next request is accepted.
//   a new request may be taken while a finished result still waits in out_ch.
//   if the receiver stalls with a result held, the update of the next request waits
//   until the held word is taken.
//   reset clears valid bits, sizes and counters, sets slot i to rank i and sets
//   the size limit register to 8192. config is an apb register at byte address 0, writes
//   should only be issued while the block is idle.
`default_nettype none

module lru_object_cache_tags_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	lruc_in_if.sink                            in_ch,
	lruc_out_if.source                         out_ch,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [2:0]                    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import lruc_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_UPD
	} state_t;

	state_t state_q;

	// config
	logic [SIZE_BITS-1:0] max_size_q;
	logic                 cfg_sel;

	assign pready  = 1'b1;
	assign cfg_sel = (paddr == 3'd0);
	assign prdata  = cfg_sel ? {{(32-SIZE_BITS){1'b0}}, max_size_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q <= SIZE_BITS'(CFG_RESET);
		end else if (psel && penable && pwrite && pready && cfg_sel) begin
			max_size_q <= pwdata[SIZE_BITS-1:0];
		end
	end

	// request registers
	logic [2:0]               op_q;
	logic [KEY_BITS-1:0]      key_q;
	logic [OBJ_SIZE_BITS-1:0] size_q;
	logic                     ok_q;
	logic                     hit_s1;
	logic [SLOT_BITS-1:0]     hit_rank_s1;

	// cell row
	cell_cmd_t  cmd;
	cell_stat_t stat [NUM_SLOTS];

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		lruc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_id    (SLOT_BITS'(i)),
			.lookup_key (in_ch.object_key),
			.cmd        (cmd),
			.stat       (stat[i])
		);
	end

	// matches indexed by rank, lowest set rank is the lru match
	logic [NUM_SLOTS-1:0] match_by_rank;
	logic                 any_match;
	logic [SLOT_BITS-1:0] low_rank;

	always_comb begin
		match_by_rank = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (stat[i].match) begin
				match_by_rank[stat[i].rank] = 1'b1;
			end
		end
		any_match = |match_by_rank;
		low_rank  = '0;
		for (int r = NUM_SLOTS - 1; r >= 0; r--) begin
			if (match_by_rank[r]) begin
				low_rank = SLOT_BITS'(r);
			end
		end
	end

	// selected slot readout, one-hot since ranks are a permutation
	logic [SLOT_BITS-1:0] sel_index;
	logic [SIZE_BITS-1:0] sel_size;

	always_comb begin
		sel_index = '0;
		sel_size  = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (stat[i].sel) begin
				sel_index = sel_index | SLOT_BITS'(i);
				sel_size  = sel_size | stat[i].size;
			end
		end
	end

	// decision for the held request
	logic [SIZE_BITS-1:0]  limit;
	logic                  fits;
	logic                  upd_go;
	act_t                  act;
	logic [SLOT_BITS-1:0]  target_rank;
	logic                  r_status;
	logic                  r_hit;
	logic                  r_written;
	logic                  r_has_slot;
	logic                  r_csize;
	logic                  inc_hit;
	logic                  inc_miss;

	assign limit  = (max_size_q < SIZE_BITS'(MAX_SIZE_LIMIT)) ? max_size_q
		: SIZE_BITS'(MAX_SIZE_LIMIT);
	assign fits   = (size_q <= {{(OBJ_SIZE_BITS-SIZE_BITS){1'b0}}, limit});
	assign upd_go = (state_q == ST_UPD) && (!out_ch.valid || out_ch.ready);

	always_comb begin
		act         = ACT_NONE;
		target_rank = '0;
		r_status    = 1'b0;
		r_hit       = 1'b0;
		r_written   = 1'b0;
		r_has_slot  = 1'b0;
		r_csize     = 1'b0;
		inc_hit     = 1'b0;
		inc_miss    = 1'b0;
		case (op_q)
			OP_ADD: begin
				if (!ok_q) begin
					r_status = 1'b1;
				end else if (fits) begin
					act        = ACT_FILL;
					inc_miss   = 1'b1;
					r_written  = 1'b1;
					r_has_slot = 1'b1;
				end
			end
			OP_REWRITE: begin
				if (!ok_q) begin
					r_status = 1'b1;
				end else if (fits) begin
					act        = ACT_FILL;
					r_written  = 1'b1;
					r_has_slot = 1'b1;
					if (hit_s1) begin
						target_rank = hit_rank_s1;
						inc_hit     = 1'b1;
						r_hit       = 1'b1;
					end else begin
						inc_miss = 1'b1;
					end
				end
			end
			OP_DELETE: begin
				if (!ok_q) begin
					r_status = 1'b1;
				end else if (hit_s1) begin
					act         = ACT_LRU;
					target_rank = hit_rank_s1;
					inc_hit     = 1'b1;
					r_hit       = 1'b1;
					r_has_slot  = 1'b1;
				end else begin
					inc_miss = 1'b1;
				end
			end
			OP_SIZE, OP_GET: begin
				if (hit_s1) begin
					act         = ACT_MRU;
					target_rank = hit_rank_s1;
					inc_hit     = 1'b1;
					r_hit       = 1'b1;
					r_has_slot  = 1'b1;
					r_csize     = 1'b1;
				end else begin
					inc_miss = 1'b1;
					if (!ok_q) begin
						r_status = 1'b1;
					end else if (op_q == OP_GET && fits) begin
						act        = ACT_FILL;
						r_written  = 1'b1;
						r_has_slot = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign cmd.act         = upd_go ? act : ACT_NONE;
	assign cmd.target_rank = target_rank;
	assign cmd.key         = key_q;
	assign cmd.size        = size_q[SIZE_BITS-1:0];

	// counters and result word
	logic [CNT_BITS-1:0] hits_q;
	logic [CNT_BITS-1:0] misses_q;
	logic [CNT_BITS-1:0] hits_next;
	logic [CNT_BITS-1:0] misses_next;

	assign hits_next   = hits_q + CNT_BITS'(inc_hit);
	assign misses_next = misses_q + CNT_BITS'(inc_miss);

	logic                 out_valid_q;
	logic                 status_q;
	logic                 hit_q;
	logic [SLOT_BITS-1:0] slot_q;
	logic                 written_q;
	logic [SIZE_BITS-1:0] csize_q;
	logic [CNT_BITS-1:0]  hit_cnt_q;
	logic [CNT_BITS-1:0]  miss_cnt_q;

	assign in_ch.ready = (state_q == ST_IDLE);

	assign out_ch.valid        = out_valid_q;
	assign out_ch.status       = status_q;
	assign out_ch.hit          = hit_q;
	assign out_ch.slot_index   = slot_q;
	assign out_ch.slot_written = written_q;
	assign out_ch.cached_size  = csize_q;
	assign out_ch.hit_count    = hit_cnt_q;
	assign out_ch.miss_count   = miss_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			hits_q      <= '0;
			misses_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (out_ch.ready) begin
						out_valid_q <= 1'b0;
					end
					if (in_ch.valid) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (upd_go) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						hits_q      <= hits_next;
						misses_q    <= misses_next;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			op_q        <= in_ch.operation;
			key_q       <= in_ch.object_key;
			size_q      <= in_ch.obj_bytes;
			ok_q        <= in_ch.store_ok;
			hit_s1      <= any_match;
			hit_rank_s1 <= low_rank;
		end
		if (upd_go) begin
			status_q   <= r_status;
			hit_q      <= r_hit;
			slot_q     <= r_has_slot ? sel_index : '0;
			written_q  <= r_written;
			csize_q    <= r_csize ? sel_size : '0;
			hit_cnt_q  <= hits_next;
			miss_cnt_q <= misses_next;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lruc_cell.sv
// lruc_cell: one cache slot holding key, valid, size and its recency rank
// depends on lruc_pkg for the command and status structs
`default_nettype none

module lruc_cell (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [lruc_pkg::SLOT_BITS-1:0] cell_id,
	input  wire logic [lruc_pkg::KEY_BITS-1:0]  lookup_key,
	input  wire lruc_pkg::cell_cmd_t            cmd,
	output lruc_pkg::cell_stat_t                stat
);
	import lruc_pkg::*;

	logic [KEY_BITS-1:0]  key_q;
	logic [SIZE_BITS-1:0] size_q;
	logic                 valid_q;
	logic [SLOT_BITS-1:0] rank_q;
	logic                 sel;

	assign sel = (rank_q == cmd.target_rank);

	assign stat.match = valid_q && (key_q == lookup_key);
	assign stat.sel   = sel;
	assign stat.rank  = rank_q;
	assign stat.size  = size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			size_q  <= '0;
			rank_q  <= cell_id;
		end else begin
			case (cmd.act)
				ACT_MRU, ACT_FILL: begin
					if (sel) begin
						rank_q <= SLOT_BITS'(NUM_SLOTS - 1);
					end else if (rank_q > cmd.target_rank) begin
						rank_q <= rank_q - 1'b1;
					end
					if (sel && cmd.act == ACT_FILL) begin
						size_q  <= cmd.size;
						valid_q <= 1'b1;
					end
				end
				ACT_LRU: begin
					if (sel) begin
						rank_q  <= '0;
						valid_q <= 1'b0;
					end else if (rank_q < cmd.target_rank) begin
						rank_q <= rank_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// keys are only compared while valid, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.act == ACT_FILL && sel) begin
			key_q <= cmd.key;
		end
	end

endmodule

`default_nettype wire

FILE: test/tb_lru_object_cache_tags_core.sv
`timescale 1ns / 1ps
// tb_lru_object_cache_tags_core: self-checking bench for the lru object cache tag core
// depends on lruc_pkg, lruc_if and the rtl; a scoreboard class tracks slots, lru ranks and counters

module tb_lru_object_cache_tags_core;
	import lruc_pkg::*;

	localparam logic [2:0] REG_SIZE_LIMIT = 3'd0;
	localparam logic [2:0] OP_BAD_LO = 3'd5;
	localparam logic [2:0] OP_BAD_HI = 3'd7;
	localparam int KEY_POOL = 48;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 3000;
	localparam int PHASE_ITEMS = 255;
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		logic [2:0]               op;
		logic [KEY_BITS-1:0]      key;
		logic [OBJ_SIZE_BITS-1:0] size;
		logic                     ok;
	} request_t;

	typedef struct packed {
		logic                 status;
		logic                 hit;
		logic [SLOT_BITS-1:0] slot;
		logic                 written;
		logic [SIZE_BITS-1:0] csize;
		logic [CNT_BITS-1:0]  hits;
		logic [CNT_BITS-1:0]  misses;
	} lookup_t;

	class tag_scoreboard;
		logic [KEY_BITS-1:0]  keys [NUM_SLOTS];
		bit                   valid [NUM_SLOTS];
		logic [SIZE_BITS-1:0] sizes [NUM_SLOTS];
		int unsigned          rank [NUM_SLOTS];
		logic [CNT_BITS-1:0]  hits;
		logic [CNT_BITS-1:0]  misses;
		logic [SIZE_BITS-1:0] max_size;
		lookup_t              due_results [$];
		int                   errors;

		function new();
			for (int i = 0; i < NUM_SLOTS; i++) begin
				keys[i] = '0;
				valid[i] = 1'b0;
				sizes[i] = '0;
				rank[i] = i;
			end
			hits = '0;
			misses = '0;
			max_size = SIZE_BITS'(CFG_RESET);
			errors = 0;
		endfunction

		function void set_max_size(logic [31:0] v);
			max_size = v[SIZE_BITS-1:0];
		endfunction

		function int size_limit();
			return (max_size < MAX_SIZE_LIMIT) ? int'(max_size) : MAX_SIZE_LIMIT;
		endfunction

		// least recently used valid match, -1 if none
		function int find_key(logic [KEY_BITS-1:0] k);
			int best;
			best = -1;
			for (int i = 0; i < NUM_SLOTS; i++)
				if (valid[i] && keys[i] == k && (best < 0 || rank[i] < rank[best]))
					best = i;
			return best;
		endfunction

		function int lru_slot();
			for (int i = 0; i < NUM_SLOTS; i++)
				if (rank[i] == 0)
					return i;
			return 0;
		endfunction

		function void promote(int s);
			int unsigned r;
			r = rank[s];
			for (int i = 0; i < NUM_SLOTS; i++)
				if (rank[i] > r)
					rank[i]--;
			rank[s] = NUM_SLOTS - 1;
		endfunction

		function void demote(int s);
			int unsigned r;
			r = rank[s];
			for (int i = 0; i < NUM_SLOTS; i++)
				if (rank[i] < r)
					rank[i]++;
			rank[s] = 0;
		endfunction

		function void fill(int s, logic [KEY_BITS-1:0] k, logic [OBJ_SIZE_BITS-1:0] sz);
			promote(s);
			keys[s] = k;
			sizes[s] = sz[SIZE_BITS-1:0];
			valid[s] = 1'b1;
		endfunction

		function void note_request(request_t r);
			lookup_t e;
			int s;
			bit fits;
			e = '0;
			fits = int'(r.size) <= size_limit();
			case (r.op)
				OP_ADD: begin
					if (!r.ok)
						e.status = 1'b1;
					else if (fits) begin
						s = lru_slot();
						fill(s, r.key, r.size);
						misses++;
						e.slot = s[SLOT_BITS-1:0];
						e.written = 1'b1;
					end
				end
				OP_REWRITE: begin
					if (!r.ok)
						e.status = 1'b1;
					else if (fits) begin
						s = find_key(r.key);
						if (s >= 0) begin
							hits++;
							e.hit = 1'b1;
						end else begin
							misses++;
							s = lru_slot();
						end
						fill(s, r.key, r.size);
						e.slot = s[SLOT_BITS-1:0];
						e.written = 1'b1;
					end
				end
				OP_DELETE: begin
					if (!r.ok)
						e.status = 1'b1;
					else begin
						s = find_key(r.key);
						if (s >= 0) begin
							demote(s);
							valid[s] = 1'b0;
							hits++;
							e.hit = 1'b1;
							e.slot = s[SLOT_BITS-1:0];
						end else
							misses++;
					end
				end
				OP_SIZE, OP_GET: begin
					s = find_key(r.key);
					if (s >= 0) begin
						promote(s);
						hits++;
						e.hit = 1'b1;
						e.slot = s[SLOT_BITS-1:0];
						e.csize = sizes[s];
					end else begin
						misses++;
						if (!r.ok)
							e.status = 1'b1;
						else if (r.op == OP_GET && fits) begin
							s = lru_slot();
							fill(s, r.key, r.size);
							e.slot = s[SLOT_BITS-1:0];
							e.written = 1'b1;
						end
					end
				end
				default: ;
			endcase
			e.hits = hits;
			e.misses = misses;
			due_results.push_back(e);
		endfunction

		function void check_result(lookup_t got);
			lookup_t e;
			if (due_results.size() == 0) begin
				$error("result word arrived with nothing expected");
				errors++;
				return;
			end
			e = due_results.pop_front();
			if (got.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, got.status);
				errors++;
			end
			if (got.hit !== e.hit) begin
				$error("hit: expected %0d, got %0d", e.hit, got.hit);
				errors++;
			end
			if (got.slot !== e.slot) begin
				$error("slot_index: expected %0d, got %0d", e.slot, got.slot);
				errors++;
			end
			if (got.written !== e.written) begin
				$error("slot_written: expected %0d, got %0d", e.written, got.written);
				errors++;
			end
			if (got.csize !== e.csize) begin
				$error("cached_size: expected %0d, got %0d", e.csize, got.csize);
				errors++;
			end
			if (got.hits !== e.hits) begin
				$error("hit_count: expected %0d, got %0d", e.hits, got.hits);
				errors++;
			end
			if (got.misses !== e.misses) begin
				$error("miss_count: expected %0d, got %0d", e.misses, got.misses);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	lruc_in_if  in_ch ();
	lruc_out_if out_ch ();

	lru_object_cache_tags_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	tag_scoreboard       sb;
	logic [KEY_BITS-1:0] key_pool [KEY_POOL];
	bit                  long_hold_req = 1'b0;
	int                  idle_cycles = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// check results first, then note new requests: a result never belongs to a word taken at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready)
				sb.check_result({out_ch.status, out_ch.hit, out_ch.slot_index, out_ch.slot_written,
					out_ch.cached_size, out_ch.hit_count, out_ch.miss_count});
			if (in_ch.valid && in_ch.ready)
				sb.note_request({in_ch.operation, in_ch.object_key, in_ch.obj_bytes,
					in_ch.store_ok});
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// receiver: stretches of random stall modes, plus one long hold-off on request
	initial begin
		int mode;
		int stretch;
		stretch = 0;
		mode = 0;
		forever begin
			if (long_hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold_req = 1'b0;
			end else begin
				if (stretch == 0) begin
					mode = $urandom_range(0, 3);
					stretch = $urandom_range(20, 200);
				end
				stretch--;
				case (mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= 1'($urandom_range(0, 1));
					2: out_ch.ready <= (stretch % 3) != 0;
					default: out_ch.ready <= $urandom_range(0, 3) == 0;
				endcase
				@(posedge clk);
			end
		end
	end

	task automatic send_request(request_t r);
		in_ch.valid <= 1'b1;
		in_ch.operation <= r.op;
		in_ch.object_key <= r.key;
		in_ch.obj_bytes <= r.size;
		in_ch.store_ok <= r.ok;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	task automatic wait_results_done();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_size(logic [31:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= REG_SIZE_LIMIT;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_max_size(v);
	endtask

	function automatic request_t random_request(int lim);
		request_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 14)
			r.op = OP_ADD;
		else if (pick < 32)
			r.op = OP_REWRITE;
		else if (pick < 44)
			r.op = OP_DELETE;
		else if (pick < 60)
			r.op = OP_SIZE;
		else if (pick < 96)
			r.op = OP_GET;
		else
			r.op = 3'($urandom_range(OP_BAD_LO, OP_BAD_HI));
		// mostly a small key set so hits, duplicates and evictions all happen
		if ($urandom_range(0, 99) < 88)
			r.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
		else
			r.key = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 75)
			r.size = OBJ_SIZE_BITS'($urandom_range(0, lim));
		else if (pick < 85)
			r.size = OBJ_SIZE_BITS'(lim + $urandom_range(1, 3));
		else if (pick < 95)
			r.size = OBJ_SIZE_BITS'($urandom);
		else
			r.size = OBJ_SIZE_BITS'($urandom_range(0, 15));
		r.ok = $urandom_range(0, 99) < 90;
		return r;
	endfunction

	task automatic run_directed();
		send_request('{OP_SIZE, 32'h0000_0000, 16'd0, 1'b0});
		send_request('{OP_GET, 32'hFFFF_FFFF, 16'd100, 1'b0});
		// duplicate key: add skips the search
		send_request('{OP_ADD, 32'h0000_0000, 16'd0, 1'b1});
		send_request('{OP_ADD, 32'h0000_0000, 16'd8192, 1'b1});
		send_request('{OP_GET, 32'h0000_0000, 16'd0, 1'b1});
		send_request('{OP_REWRITE, 32'h0000_0000, 16'd100, 1'b1});
		send_request('{OP_SIZE, 32'h0000_0000, 16'd0, 1'b0});
		send_request('{OP_DELETE, 32'h0000_0000, 16'd0, 1'b0});
		send_request('{OP_DELETE, 32'h0000_0000, 16'd0, 1'b1});
		send_request('{OP_DELETE, 32'h0000_0000, 16'd0, 1'b1});
		send_request('{OP_DELETE, 32'h0000_0000, 16'd0, 1'b1});
		// oversize objects are never cached
		send_request('{OP_ADD, 32'hFFFF_FFFF, 16'd8193, 1'b1});
		send_request('{OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, 1'b1});
		send_request('{OP_ADD, 32'hFFFF_FFFF, 16'd8192, 1'b0});
		send_request('{OP_REWRITE, 32'h1234_5678, 16'd1, 1'b1});
		send_request('{OP_REWRITE, 32'h1234_5678, 16'd8193, 1'b1});
		send_request('{OP_REWRITE, 32'h1234_5678, 16'd7, 1'b0});
		send_request('{OP_GET, 32'hA5A5_5A5A, 16'd8193, 1'b1});
		send_request('{OP_GET, 32'hA5A5_5A5A, 16'd5, 1'b1});
		send_request('{OP_GET, 32'hA5A5_5A5A, 16'd0, 1'b1});
		send_request('{OP_SIZE, 32'h1234_5678, 16'd0, 1'b1});
		for (int op = OP_BAD_LO; op <= OP_BAD_HI; op++)
			send_request('{op[2:0], 32'hFFFF_FFFF, 16'hFFFF, 1'b1});
		send_request('{OP_SIZE, 32'h5A5A_A5A5, 16'd0, 1'b1});
	endtask

	task automatic run_phase(int n, bit gaps, bit with_hold);
		int burst;
		burst = $urandom_range(1, 20);
		for (int i = 0; i < n; i++) begin
			if (with_hold && i == 20)
				long_hold_req = 1'b1;
			if (i == n / 2)
				wait_results_done();
			send_request(random_request(sb.size_limit()));
			burst--;
			if (burst == 0) begin
				burst = $urandom_range(1, 20);
				if (gaps) begin
					in_ch.valid <= 1'b0;
					repeat ($urandom_range(1, 8)) @(posedge clk);
				end
			end
		end
	endtask

	initial begin
		logic [31:0] phase_cfg [5];
		phase_cfg = '{32'd16383, 32'd0, 32'd777, 32'd8191, 32'd8192};
		sb = new();
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < KEY_POOL; i++)
			key_pool[i] = $urandom;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.operation <= '0;
		in_ch.object_key <= '0;
		in_ch.obj_bytes <= '0;
		in_ch.store_ok <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		run_directed();
		wait_results_done();
		for (int p = 0; p < 5; p++) begin
			write_max_size(phase_cfg[p]);
			run_phase(PHASE_ITEMS, p != 2, p == 1);
			wait_results_done();
		end
		repeat (8) @(posedge clk);

		if (sb.errors == 0 && sb.due_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
